FILE: rtl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg: shared definitions for the coinbase prefix parser
// Status codes, result kinds, parse phases, tag values and register defaults.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int MAX_OUTPUTS_DEF      = 32;
    localparam int MAX_VARINT_BYTES     = 10;

    localparam logic [15:0] MAX_EXTRA_RESET = 16'd1024;
    localparam logic [5:0]  MIN_OUT_RESET   = 6'd2;
    localparam logic [5:0]  MAX_OUT_RESET   = 6'd32;

    localparam logic [1:0] REG_MAX_EXTRA = 2'd0;
    localparam logic [1:0] REG_MIN_OUT   = 2'd1;
    localparam logic [1:0] REG_MAX_OUT   = 2'd2;

    localparam logic [7:0] TAG_PUBKEY   = 8'd22;
    localparam logic [7:0] TAG_ATTACH   = 8'd18;
    localparam logic [7:0] TAG_BLOB_A   = 8'd11;
    localparam logic [7:0] TAG_BLOB_B   = 8'd19;
    localparam logic [7:0] TAG_BLOB_C   = 8'd21;
    localparam logic [7:0] TAG_VAR_A    = 8'd14;
    localparam logic [7:0] TAG_VAR_B    = 8'd15;
    localparam logic [7:0] TAG_VAR_C    = 8'd16;
    localparam logic [7:0] TAG_VAR_D    = 8'd78;
    localparam logic [7:0] OUT_TAG      = 8'd63;
    localparam logic [7:0] TRAILER_BYTE = 8'd6;
    localparam logic [63:0] TX_VERSION  = 64'd4;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_ASSET  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_VERSION   = 4'd1,
        ST_INPUT     = 4'd2,
        ST_OVERFLOW  = 4'd3,
        ST_NONCANON  = 4'd4,
        ST_LONG      = 4'd5,
        ST_XCOUNT    = 4'd6,
        ST_TAG       = 4'd7,
        ST_DUPKEY    = 4'd8,
        ST_NOKEY     = 4'd9,
        ST_OCOUNT    = 4'd10,
        ST_OFORM     = 4'd11,
        ST_TRAILER   = 4'd12,
        ST_TRUNCATED = 4'd13
    } status_t;

    typedef enum logic [20:0] {
        PH_VER     = 21'h000001,
        PH_INCNT   = 21'h000002,
        PH_INTYPE  = 21'h000004,
        PH_HEIGHT  = 21'h000008,
        PH_XCNT    = 21'h000010,
        PH_TAG     = 21'h000020,
        PH_BLOBLEN = 21'h000040,
        PH_SKIPN   = 21'h000080,
        PH_VARSKIP = 21'h000100,
        PH_ATT1    = 21'h000200,
        PH_ATT32   = 21'h000400,
        PH_ATT2    = 21'h000800,
        PH_KEY     = 21'h001000,
        PH_OCNT    = 21'h002000,
        PH_OTAG    = 21'h004000,
        PH_OMIX    = 21'h008000,
        PH_STEALTH = 21'h010000,
        PH_COMMIT  = 21'h020000,
        PH_ASSET   = 21'h040000,
        PH_TAIL    = 21'h080000,
        PH_TRAILER = 21'h100000
    } phase_t;

endpackage

FILE: rtl/coinbase_prefix_parser.sv
// ----------------------------------------------------------------------------
// coinbase_prefix_parser: byte-serial miner-transaction prefix checker
// Decodes varints and tagged extra fields, checks the outputs and streams out
// key, commitment and asset id bytes plus one status beat per prefix.
// ----------------------------------------------------------------------------
// Path: input register, then parse logic, then result register.
// Throughput: one byte per cycle unless the result register stalls; the limit
// is the single parse-state update.
// Reset (rst_n, asynchronous, active low) returns the parser to the version
// varint and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module coinbase_prefix_parser
    import cpp_pkg::*;
#(
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] out_index, [9:5] byte_index, [17:10] data, [21:18] status,
    // [27:22] num_outputs, [31:28] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int OT_W = $clog2(MAX_OUTPUTS + 1);

    // Configuration registers; writes are taken in any cycle.
    logic [15:0] max_extra_reg;
    logic [5:0]  min_out_reg;
    logic [5:0]  max_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_extra_reg <= MAX_EXTRA_RESET;
            min_out_reg   <= MIN_OUT_RESET;
            max_out_reg   <= MAX_OUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_EXTRA: max_extra_reg <= cfg_data;
                REG_MIN_OUT:   min_out_reg   <= cfg_data[5:0];
                REG_MAX_OUT:   max_out_reg   <= cfg_data[5:0];
                default:       ;
            endcase
        end
    end

    // Input register: the beat waits here until the result register is free.
    logic       in_v_reg;
    logic [7:0] in_b_reg;
    logic       in_l_reg;
    logic       out_free;
    logic       proc;

    assign out_free = !m_tvalid || m_tready;
    assign proc     = in_v_reg && out_free;
    assign s_tready = !in_v_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_tready)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_b_reg <= s_tdata;
            in_l_reg <= s_tlast;
        end
    end

    // Parse state.
    phase_t          phase_reg,   phase_next;
    logic [63:0]     vval_reg,    vval_next;
    logic [3:0]      vshift_reg,  vshift_next;
    logic [63:0]     skip_reg,    skip_next;
    logic [15:0]     extra_reg,   extra_next;
    logic [OT_W-1:0] ototal_reg,  ototal_next;
    logic [OT_W-1:0] onum_reg,    onum_next;
    logic [6:0]      fbyte_reg,   fbyte_next;
    logic            key_reg,     key_next;
    logic            err_reg,     err_next;

    // Varint byte decode, shared by every varint phase.
    logic [5:0]  vpos;
    logic [63:0] vword;
    logic        v_ovf;
    logic        v_nc;
    logic        v_long;

    assign vpos   = 6'({2'b00, vshift_reg} * 6'd7);
    assign vword  = vval_reg | ({57'd0, in_b_reg[6:0]} << vpos);
    assign v_ovf  = (vpos == 6'd63) && (in_b_reg[6:1] != 6'd0);
    assign v_nc   = (vshift_reg != 4'd0) && (in_b_reg[6:0] == 7'd0);
    assign v_long = 32'(vshift_reg) + 1 >= MAX_VARINT_BYTES;

    logic [63:0] hi64;
    assign hi64 = (64'(max_out_reg) < 64'(MAX_OUTPUTS)) ? 64'(max_out_reg)
                                                        : 64'(MAX_OUTPUTS);

    logic    res_v;
    kind_t   res_kind;
    logic [4:0] res_oi;
    logic [4:0] res_bi;
    logic [7:0] res_data;
    status_t res_st;
    logic [5:0] res_no;

    always_comb
    begin
        logic       st_v;
        status_t    st;
        logic       dv;
        logic       v_done;
        logic       end_fld;
        logic       after_x;
        logic       clr;
        logic [15:0] x_dec;

        phase_next  = phase_reg;
        vval_next   = vval_reg;
        vshift_next = vshift_reg;
        skip_next   = skip_reg;
        extra_next  = extra_reg;
        ototal_next = ototal_reg;
        onum_next   = onum_reg;
        fbyte_next  = fbyte_reg;
        key_next    = key_reg;
        err_next    = err_reg;
        st_v = 1'b0;
        st   = ST_OK;
        dv   = 1'b0;
        v_done  = 1'b0;
        end_fld = 1'b0;
        after_x = 1'b0;
        clr     = 1'b0;
        x_dec   = 16'd0;
        res_kind = KIND_KEY;
        res_oi   = 5'd0;
        res_bi   = 5'd0;

        if (phase_reg == PH_VER || phase_reg == PH_INCNT || phase_reg == PH_HEIGHT ||
            phase_reg == PH_XCNT || phase_reg == PH_BLOBLEN || phase_reg == PH_VARSKIP ||
            phase_reg == PH_ATT1 || phase_reg == PH_ATT2 || phase_reg == PH_OCNT)
        begin
            if (v_ovf)
            begin
                st_v = 1'b1;
                st   = ST_OVERFLOW;
            end
            else if (!in_b_reg[7])
            begin
                if (v_nc)
                begin
                    st_v = 1'b1;
                    st   = ST_NONCANON;
                end
                else
                begin
                    v_done      = 1'b1;
                    vshift_next = 4'd0;
                    vval_next   = 64'd0;
                end
            end
            else if (v_long)
            begin
                st_v = 1'b1;
                st   = ST_LONG;
            end
            else
            begin
                vval_next   = vword;
                vshift_next = vshift_reg + 4'd1;
            end
        end

        unique case (phase_reg)
            PH_VER:
                if (v_done)
                begin
                    if (vword != TX_VERSION)
                    begin
                        st_v = 1'b1;
                        st   = ST_VERSION;
                    end
                    else
                        phase_next = PH_INCNT;
                end
            PH_INCNT:
                if (v_done)
                begin
                    if (vword != 64'd1)
                    begin
                        st_v = 1'b1;
                        st   = ST_INPUT;
                    end
                    else
                        phase_next = PH_INTYPE;
                end
            PH_HEIGHT:
                if (v_done)
                    phase_next = PH_XCNT;
            PH_XCNT:
                if (v_done)
                begin
                    if (vword > 64'(max_extra_reg))
                    begin
                        st_v = 1'b1;
                        st   = ST_XCOUNT;
                    end
                    else
                    begin
                        extra_next = vword[15:0];
                        if (vword[15:0] == 16'd0)
                            after_x = 1'b1;
                        else
                            phase_next = PH_TAG;
                    end
                end
            PH_BLOBLEN:
                if (v_done)
                begin
                    skip_next = vword;
                    if (vword == 64'd0)
                        end_fld = 1'b1;
                    else
                        phase_next = PH_SKIPN;
                end
            PH_VARSKIP, PH_ATT2:
                if (v_done)
                    end_fld = 1'b1;
            PH_ATT1:
                if (v_done)
                begin
                    fbyte_next = 7'd0;
                    phase_next = PH_ATT32;
                end
            PH_OCNT:
                if (v_done)
                begin
                    if (vword < 64'(min_out_reg) || vword > hi64)
                    begin
                        st_v = 1'b1;
                        st   = ST_OCOUNT;
                    end
                    else
                    begin
                        ototal_next = vword[OT_W-1:0];
                        onum_next   = '0;
                        phase_next  = (vword == 64'd0) ? PH_TRAILER : PH_OTAG;
                    end
                end
            PH_INTYPE:
                if (in_b_reg != 8'd0)
                begin
                    st_v = 1'b1;
                    st   = ST_INPUT;
                end
                else
                    phase_next = PH_HEIGHT;
            PH_TAG:
            begin
                fbyte_next = 7'd0;
                if (in_b_reg == TAG_BLOB_A || in_b_reg == TAG_BLOB_B ||
                    in_b_reg == TAG_BLOB_C)
                    phase_next = PH_BLOBLEN;
                else if (in_b_reg == TAG_VAR_A || in_b_reg == TAG_VAR_B ||
                         in_b_reg == TAG_VAR_C || in_b_reg == TAG_VAR_D)
                    phase_next = PH_VARSKIP;
                else if (in_b_reg == TAG_ATTACH)
                    phase_next = PH_ATT1;
                else if (in_b_reg == TAG_PUBKEY)
                begin
                    if (key_reg)
                    begin
                        st_v = 1'b1;
                        st   = ST_DUPKEY;
                    end
                    else
                        phase_next = PH_KEY;
                end
                else
                begin
                    st_v = 1'b1;
                    st   = ST_TAG;
                end
            end
            PH_SKIPN:
            begin
                skip_next = skip_reg - 64'd1;
                if (skip_reg == 64'd1)
                    end_fld = 1'b1;
            end
            PH_ATT32:
            begin
                fbyte_next = fbyte_reg + 7'd1;
                if (fbyte_reg + 7'd1 >= 7'd32)
                    phase_next = PH_ATT2;
            end
            PH_KEY:
            begin
                dv         = 1'b1;
                res_kind   = KIND_KEY;
                res_bi     = fbyte_reg[4:0];
                fbyte_next = fbyte_reg + 7'd1;
                if (fbyte_reg + 7'd1 >= 7'd32)
                begin
                    key_next = 1'b1;
                    end_fld  = 1'b1;
                end
            end
            PH_OTAG:
                if (in_b_reg != OUT_TAG)
                begin
                    st_v = 1'b1;
                    st   = ST_OFORM;
                end
                else
                    phase_next = PH_OMIX;
            PH_OMIX:
                if (in_b_reg != 8'd0)
                begin
                    st_v = 1'b1;
                    st   = ST_OFORM;
                end
                else
                begin
                    fbyte_next = 7'd0;
                    phase_next = PH_STEALTH;
                end
            PH_STEALTH:
            begin
                fbyte_next = fbyte_reg + 7'd1;
                if (fbyte_reg + 7'd1 >= 7'd64)
                begin
                    fbyte_next = 7'd0;
                    phase_next = PH_COMMIT;
                end
            end
            PH_COMMIT, PH_ASSET:
            begin
                dv         = 1'b1;
                res_kind   = (phase_reg == PH_COMMIT) ? KIND_COMMIT : KIND_ASSET;
                res_oi     = 5'(onum_reg);
                res_bi     = fbyte_reg[4:0];
                fbyte_next = fbyte_reg + 7'd1;
                if (fbyte_reg + 7'd1 >= 7'd32)
                begin
                    fbyte_next = 7'd0;
                    phase_next = (phase_reg == PH_COMMIT) ? PH_ASSET : PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                fbyte_next = fbyte_reg + 7'd1;
                if (fbyte_reg + 7'd1 >= 7'd17)
                begin
                    fbyte_next = 7'd0;
                    onum_next  = onum_reg + 1'b1;
                    phase_next = (onum_reg + 1'b1 >= ototal_reg) ? PH_TRAILER : PH_OTAG;
                end
            end
            PH_TRAILER:
            begin
                st_v = 1'b1;
                st   = (in_b_reg == TRAILER_BYTE && in_l_reg) ? ST_OK : ST_TRAILER;
            end
            default:
            begin
                st_v = 1'b1;
                st   = ST_TRAILER;
            end
        endcase

        // Closing an extra field, then possibly the whole extra section.
        if (end_fld)
        begin
            x_dec      = extra_reg - 16'd1;
            extra_next = x_dec;
            if (x_dec == 16'd0)
                after_x = 1'b1;
            else
                phase_next = PH_TAG;
        end
        if (after_x)
        begin
            if (!key_next)
            begin
                st_v = 1'b1;
                st   = ST_NOKEY;
            end
            else
                phase_next = PH_OCNT;
        end

        if (!st_v && in_l_reg)
        begin
            st_v = 1'b1;
            st   = ST_TRUNCATED;
        end

        res_v    = st_v || dv;
        res_data = in_b_reg;
        res_st   = st;
        res_no   = 6'(ototal_reg);
        if (st_v)
        begin
            res_kind = KIND_STATUS;
            res_oi   = 5'd0;
            res_bi   = 5'd0;
            res_data = 8'd0;
            if (in_l_reg)
                clr = 1'b1;
            else
                err_next = 1'b1;
        end
        else
        begin
            res_st = ST_OK;
            res_no = 6'd0;
        end

        // After an error every byte is dropped; the final one also rearms the parser.
        if (err_reg)
        begin
            res_v = 1'b0;
            clr   = in_l_reg;
            if (!in_l_reg)
            begin
                phase_next  = phase_reg;
                vval_next   = vval_reg;
                vshift_next = vshift_reg;
                skip_next   = skip_reg;
                extra_next  = extra_reg;
                ototal_next = ototal_reg;
                onum_next   = onum_reg;
                fbyte_next  = fbyte_reg;
                key_next    = key_reg;
                err_next    = err_reg;
            end
        end

        if (clr)
        begin
            phase_next  = PH_VER;
            vval_next   = 64'd0;
            vshift_next = 4'd0;
            skip_next   = 64'd0;
            extra_next  = 16'd0;
            ototal_next = '0;
            onum_next   = '0;
            fbyte_next  = 7'd0;
            key_next    = 1'b0;
            err_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_VER;
            vval_reg   <= 64'd0;
            vshift_reg <= 4'd0;
            skip_reg   <= 64'd0;
            extra_reg  <= 16'd0;
            ototal_reg <= '0;
            onum_reg   <= '0;
            fbyte_reg  <= 7'd0;
            key_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg  <= phase_next;
            vval_reg   <= vval_next;
            vshift_reg <= vshift_next;
            skip_reg   <= skip_next;
            extra_reg  <= extra_next;
            ototal_reg <= ototal_next;
            onum_reg   <= onum_next;
            fbyte_reg  <= fbyte_next;
            key_reg    <= key_next;
            err_reg    <= err_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (out_free)
            m_tvalid <= proc && res_v;
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_v && out_free)
        begin
            m_tuser <= res_kind;
            m_tdata <= {4'd0, res_no, res_st, res_data, res_bi, res_oi};
        end
    end

    // A byte that follows an error never yields a beat.
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        proc && err_reg |-> !res_v)
        else $error("result produced while an error is pending");

    // The final byte always rearms the parser.
    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_l_reg |=> !err_reg && phase_reg == PH_VER)
        else $error("final byte did not rearm the parser");

    // A data beat is never produced by the final byte.
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_v && in_l_reg |-> res_kind == KIND_STATUS)
        else $error("final byte produced a data beat");

    // While outputs are walked the output number stays below the count.
    a_onum_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OTAG || phase_reg == PH_COMMIT |-> onum_reg < ototal_reg)
        else $error("output number beyond output count");

endmodule

FILE: tb/sv/coinbase_prefix_parser_test.sv
// ----------------------------------------------------------------------------
// coinbase_prefix_parser_test: self-checking bench for the prefix parser
// Streams directed and random transaction prefixes into the parser, predicts
// every key, commitment, asset id and status beat, and compares each result
// beat field by field in arrival order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module coinbase_prefix_parser_test;
    import cpp_pkg::*;

    // One expected result beat.
    typedef struct packed {
        kind_t      kind;
        logic [4:0] out_index;
        logic [4:0] byte_index;
        logic [7:0] data;
        status_t    status;
        logic [5:0] num_outputs;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    coinbase_prefix_parser uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Predictor copy of the registers and of the parse state.
    logic [15:0] max_extra_q;
    logic [5:0]  min_out_q;
    logic [5:0]  max_out_q;
    phase_t      ph;
    logic [63:0] var_acc;
    int unsigned var_len;
    logic [63:0] skip_cnt;
    logic [15:0] fields_left;
    logic [5:0]  outs_total;
    logic [5:0]  out_num;
    int unsigned fbyte;
    bit          have_key;
    bit          in_error;

    result_t     expected_q[$];
    int          fail_count;
    int          beats_sent;
    int          results_seen;
    int          status_seen;

    function automatic void restart_prefix();
        ph = PH_VER;
        var_acc = '0;
        var_len = 0;
        skip_cnt = '0;
        fields_left = '0;
        outs_total = '0;
        out_num = '0;
        fbyte = 0;
        have_key = 1'b0;
        in_error = 1'b0;
    endfunction

    // Appends one predicted beat to the tail of the expected queue.
    function automatic void queue_result(input result_t r);
        expected_q = {expected_q, r};
    endfunction

    // Returns -1 while the varint is open, 0 once complete, else a status code.
    function automatic int take_varint_byte(input logic [7:0] b);
        int unsigned sh;
        sh = var_len * 7;
        if (sh == 63 && (b & 8'h7e) != 0)
            return ST_OVERFLOW;
        if (sh < 64)
            var_acc |= 64'(b[6:0]) << sh;
        if (!b[7])
        begin
            if (var_len != 0 && b[6:0] == 0)
                return ST_NONCANON;
            var_len = 0;
            return 0;
        end
        if (var_len + 1 >= MAX_VARINT_BYTES)
            return ST_LONG;
        var_len++;
        return -1;
    endfunction

    function automatic int close_extras();
        if (!have_key)
            return ST_NOKEY;
        ph = PH_OCNT;
        return -1;
    endfunction

    function automatic int close_field();
        fields_left = fields_left - 16'd1;
        if (fields_left == 0)
            return close_extras();
        ph = PH_TAG;
        return -1;
    endfunction

    // Advances the predictor by one accepted byte and queues any result.
    function automatic void predict_byte(input logic [7:0] b, input bit lst);
        int      st;
        int      r;
        bit      is_data;
        result_t res;
        logic [63:0] v;
        logic [5:0]  hi;
        st = -1;
        is_data = 1'b0;
        res = '0;
        if (in_error)
        begin
            if (lst)
                restart_prefix();
            return;
        end
        case (ph)
            PH_VER, PH_INCNT, PH_HEIGHT, PH_XCNT, PH_BLOBLEN, PH_VARSKIP, PH_ATT1,
            PH_ATT2, PH_OCNT:
            begin
                r = take_varint_byte(b);
                if (r > 0)
                    st = r;
                else if (r == 0)
                begin
                    v = var_acc;
                    var_acc = '0;
                    case (ph)
                        PH_VER:    if (v != TX_VERSION) st = ST_VERSION; else ph = PH_INCNT;
                        PH_INCNT:  if (v != 1) st = ST_INPUT; else ph = PH_INTYPE;
                        PH_HEIGHT: ph = PH_XCNT;
                        PH_XCNT:
                            if (v > 64'(max_extra_q))
                                st = ST_XCOUNT;
                            else
                            begin
                                fields_left = v[15:0];
                                if (fields_left == 0)
                                    st = close_extras();
                                else
                                    ph = PH_TAG;
                            end
                        PH_BLOBLEN:
                        begin
                            skip_cnt = v;
                            if (v == 0)
                                st = close_field();
                            else
                                ph = PH_SKIPN;
                        end
                        PH_VARSKIP, PH_ATT2: st = close_field();
                        PH_ATT1:
                        begin
                            fbyte = 0;
                            ph = PH_ATT32;
                        end
                        default:
                        begin
                            hi = (max_out_q < 6'(MAX_OUTPUTS_DEF)) ? max_out_q
                                                                     : 6'(MAX_OUTPUTS_DEF);
                            if (v < 64'(min_out_q) || v > 64'(hi))
                                st = ST_OCOUNT;
                            else
                            begin
                                outs_total = v[5:0];
                                out_num = '0;
                                ph = (outs_total == 0) ? PH_TRAILER : PH_OTAG;
                            end
                        end
                    endcase
                end
            end
            PH_INTYPE: if (b != 0) st = ST_INPUT; else ph = PH_HEIGHT;
            PH_TAG:
            begin
                fbyte = 0;
                if (b == TAG_BLOB_A || b == TAG_BLOB_B || b == TAG_BLOB_C)
                    ph = PH_BLOBLEN;
                else if (b == TAG_VAR_A || b == TAG_VAR_B || b == TAG_VAR_C || b == TAG_VAR_D)
                    ph = PH_VARSKIP;
                else if (b == TAG_ATTACH)
                    ph = PH_ATT1;
                else if (b == TAG_PUBKEY)
                begin
                    if (have_key)
                        st = ST_DUPKEY;
                    else
                        ph = PH_KEY;
                end
                else
                    st = ST_TAG;
            end
            PH_SKIPN:
            begin
                skip_cnt--;
                if (skip_cnt == 0)
                    st = close_field();
            end
            PH_ATT32:
            begin
                fbyte++;
                if (fbyte >= 32)
                    ph = PH_ATT2;
            end
            PH_KEY:
            begin
                is_data = 1'b1;
                res.kind = KIND_KEY;
                res.byte_index = 5'(fbyte);
                fbyte++;
                if (fbyte >= 32)
                begin
                    have_key = 1'b1;
                    st = close_field();
                end
            end
            PH_OTAG: if (b != OUT_TAG) st = ST_OFORM; else ph = PH_OMIX;
            PH_OMIX:
                if (b != 0)
                    st = ST_OFORM;
                else
                begin
                    fbyte = 0;
                    ph = PH_STEALTH;
                end
            PH_STEALTH:
            begin
                fbyte++;
                if (fbyte >= 64)
                begin
                    fbyte = 0;
                    ph = PH_COMMIT;
                end
            end
            PH_COMMIT, PH_ASSET:
            begin
                is_data = 1'b1;
                res.kind = (ph == PH_COMMIT) ? KIND_COMMIT : KIND_ASSET;
                res.out_index = out_num[4:0];
                res.byte_index = 5'(fbyte);
                fbyte++;
                if (fbyte >= 32)
                begin
                    fbyte = 0;
                    ph = (ph == PH_COMMIT) ? PH_ASSET : PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                fbyte++;
                if (fbyte >= 17)
                begin
                    fbyte = 0;
                    out_num++;
                    ph = (out_num >= outs_total) ? PH_TRAILER : PH_OTAG;
                end
            end
            default: st = (b == TRAILER_BYTE && lst) ? ST_OK : ST_TRAILER;
        endcase

        // A final byte that neither completes the prefix nor fails reads as truncated.
        if (st < 0 && lst)
            st = ST_TRUNCATED;

        if (st >= 0)
        begin
            res = '0;
            res.kind = KIND_STATUS;
            res.status = status_t'(st);
            res.num_outputs = outs_total;
            queue_result(res);
            if (lst)
                restart_prefix();
            else
                in_error = 1'b1;
        end
        else if (is_data)
        begin
            res.data = b;
            queue_result(res);
        end
    endfunction

    // Sends one byte after a random gap and predicts its effect on acceptance.
    task automatic send_byte(input logic [7:0] b, input bit lst);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, lst);
        beats_sent++;
    endtask

    task automatic send_varint(input logic [63:0] v, input bit lst);
        logic [63:0] w;
        w = v;
        while (w >= 128)
        begin
            send_byte({1'b1, w[6:0]}, 1'b0);
            w = w >> 7;
        end
        send_byte({1'b0, w[6:0]}, lst);
    endtask

    task automatic send_bytes(input int n, input logic [7:0] fill);
        repeat (n) send_byte(fill == 8'hff ? 8'($urandom) : fill, 1'b0);
    endtask

    // Waits until every predicted beat has come back, then lets the clock run on.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_EXTRA: max_extra_q = val;
            REG_MIN_OUT:   min_out_q = val[5:0];
            default:       max_out_q = val[5:0];
        endcase
        @(posedge clk);
    endtask

    // Sends one extra field of a randomly chosen kind; a key when asked.
    task automatic send_extra(input bit key);
        int pick;
        logic [7:0] tag_list[7];
        tag_list = '{TAG_BLOB_A, TAG_BLOB_B, TAG_BLOB_C, TAG_VAR_A, TAG_VAR_B, TAG_VAR_C,
                     TAG_VAR_D};
        if (key)
        begin
            send_byte(TAG_PUBKEY, 1'b0);
            send_bytes(32, 8'hff);
            return;
        end
        pick = $urandom_range(0, 7);
        if (pick == 7)
        begin
            send_byte(TAG_ATTACH, 1'b0);
            send_varint(64'($urandom), 1'b0);
            send_bytes(32, 8'hff);
            send_varint(64'($urandom_range(0, 300)), 1'b0);
        end
        else
        begin
            send_byte(tag_list[pick], 1'b0);
            if (pick < 3)
            begin
                pick = $urandom_range(0, 5);
                send_varint(64'(pick), 1'b0);
                send_bytes(pick, 8'hff);
            end
            else
                send_varint({$urandom, $urandom}, 1'b0);
        end
    endtask

    // A complete prefix; corrupt == 1 spoils one random byte position of the stream
    // by cutting it short or inserting a stray byte.  Once the parser has flagged
    // an error the rest of the prefix would be dropped, so only the final byte goes.
    task automatic send_prefix(input int n_extra, input int n_out, input int corrupt);
        int key_at;
        int budget;
        key_at = $urandom_range(0, n_extra > 0 ? n_extra - 1 : 0);
        budget = corrupt;
        send_varint(TX_VERSION, 1'b0);
        send_varint(64'd1, 1'b0);
        send_byte(8'd0, 1'b0);
        send_varint({$urandom, $urandom} >> $urandom_range(0, 63), 1'b0);
        send_varint(64'(n_extra), 1'b0);
        if (in_error)
        begin
            send_byte(TRAILER_BYTE, 1'b1);
            return;
        end
        for (int i = 0; i < n_extra; i++)
        begin
            send_extra(i == key_at);
            if (budget == 1 && $urandom_range(0, 3) == 0)
            begin
                send_byte(8'($urandom), $urandom_range(0, 1));
                budget = 0;
            end
        end
        if (in_error)
        begin
            send_byte(TRAILER_BYTE, 1'b1);
            return;
        end
        send_varint(64'(n_out), 1'b0);
        if (in_error)
        begin
            send_byte(TRAILER_BYTE, 1'b1);
            return;
        end
        for (int j = 0; j < n_out; j++)
        begin
            send_byte(OUT_TAG, 1'b0);
            send_byte(8'd0, 1'b0);
            send_bytes(64, 8'hff);
            send_bytes(64, 8'hff);
            send_bytes(17, 8'hff);
            if (budget == 1 && $urandom_range(0, 1) == 0)
            begin
                send_byte(8'($urandom), 1'b1);
                budget = 0;
            end
        end
        if (budget == 1)
            send_byte(TRAILER_BYTE, 1'b0);
        send_byte(TRAILER_BYTE, 1'b1);
    endtask

    // Field extremes, most status codes and each odd case in turn.
    task automatic test_directed();
        send_prefix(1, 2, 0);
        send_varint(64'd5, 1'b1);                                 // wrong version
        send_varint(TX_VERSION, 1'b0); send_varint(64'd2, 1'b1);  // two inputs
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0);
        send_byte(8'd1, 1'b1);                                    // input type not generation
        // Overflow on the tenth group, after nine full groups.
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        repeat (9) send_byte(8'hff, 1'b0);
        send_byte(8'h02, 1'b1);
        repeat (9) send_byte(8'hff, 1'b0);
        send_byte(8'h81, 1'b1);                                   // long varint
        send_byte(8'h84, 1'b0); send_byte(8'h00, 1'b1);           // non-canonical
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        send_varint(64'hffff_ffff_ffff_ffff, 1'b0); send_varint(64'd0, 1'b1); // no key
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        send_varint(64'd0, 1'b0); send_varint(64'd2000, 1'b1);    // extra count too big
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        send_varint(64'd0, 1'b0); send_varint(64'd3, 1'b0);
        send_byte(8'hff, 1'b0); send_byte(8'd0, 1'b1);            // bad tag, then ignored
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        send_varint(64'd0, 1'b0); send_varint(64'd2, 1'b0);
        send_extra(1'b1); send_extra(1'b1);                       // duplicate key
        send_byte(8'd0, 1'b1);
        send_varint(TX_VERSION, 1'b0); send_byte(8'd1, 1'b1);     // truncated
        send_prefix(1, 33, 0);                                    // output count too big
        send_prefix(1, 2, 1);                                     // one byte spoiled
        send_byte(8'd0, 1'b1);
        drain();
    endtask

    // Zero outputs and the largest count, under extreme register settings.
    task automatic test_registers();
        write_reg(REG_MIN_OUT, 16'd0);
        write_reg(REG_MAX_OUT, 16'd63);
        write_reg(REG_MAX_EXTRA, 16'hffff);
        send_prefix(1, 0, 0);
        // The largest output count is taken, then the prefix is cut short on the
        // first output tag so that the status carries the full count.
        send_varint(TX_VERSION, 1'b0); send_varint(64'd1, 1'b0); send_byte(8'd0, 1'b0);
        send_varint(64'd7, 1'b0); send_varint(64'd1, 1'b0);
        send_extra(1'b1);
        send_varint(64'd32, 1'b0);
        send_byte(OUT_TAG, 1'b1);
        drain();
        write_reg(REG_MAX_EXTRA, 16'd0);
        send_prefix(1, 1, 0);                                     // one field over the limit
        drain();
        write_reg(REG_MAX_EXTRA, 16'd4);
        write_reg(REG_MIN_OUT, 16'd32);
        write_reg(REG_MAX_OUT, 16'd1);
        send_prefix(2, 1, 0);                                     // empty window
        drain();
        write_reg(REG_MIN_OUT, 16'd1);
        write_reg(REG_MAX_OUT, 16'd1);
        send_prefix(1, 1, 0);
        send_prefix(1, 2, 0);
        drain();
    endtask

    // Mostly well-formed prefixes with random content, some broken, some noise.
    task automatic test_random();
        int mode;
        while (beats_sent < 1650)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
                send_prefix($urandom_range(1, 4), $urandom_range(1, 2), 0);
            else if (mode < 8)
                send_prefix($urandom_range(1, 4), $urandom_range(0, 2), 1);
            else
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0)
            begin
                send_byte(8'd0, 1'b1);                            // rearm the parser
                drain();
                write_reg(REG_MAX_EXTRA, 16'($urandom_range(1, 6)));
                write_reg(REG_MIN_OUT, 16'($urandom_range(0, 2)));
                write_reg(REG_MAX_OUT, 16'($urandom_range(2, 32)));
            end
        end
        send_byte(8'd0, 1'b1);
        drain();
    endtask

    // Result side: random back-pressure with runs of none, checking each beat.
    initial
    begin
        result_t exp;
        int stall;
        m_tready = 1'b0;
        forever
        begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat kind=%0d tdata=%h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                exp = expected_q.pop_front();
                if (m_tuser == KIND_STATUS)
                    status_seen++;
                if (m_tuser !== exp.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[4:0] !== exp.out_index)
                begin
                    $error("out_index: expected %0d, got %0d", exp.out_index, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tdata[9:5] !== exp.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d", exp.byte_index, m_tdata[9:5]);
                    fail_count++;
                end
                if (m_tdata[17:10] !== exp.data)
                begin
                    $error("data: expected %h, got %h", exp.data, m_tdata[17:10]);
                    fail_count++;
                end
                if (m_tdata[21:18] !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, m_tdata[21:18]);
                    fail_count++;
                end
                if (m_tdata[27:22] !== exp.num_outputs)
                begin
                    $error("num_outputs: expected %0d, got %0d", exp.num_outputs,
                           m_tdata[27:22]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        beats_sent = 0;
        results_seen = 0;
        status_seen = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_EXTRA;
        cfg_data = '0;
        max_extra_q = MAX_EXTRA_RESET;
        min_out_q = MIN_OUT_RESET;
        max_out_q = MAX_OUT_RESET;
        restart_prefix();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random();
        $display("Sent %0d prefix bytes; checked %0d result beats, %0d of them status.",
                 beats_sent, results_seen, status_seen);
        if (fail_count == 0)
            $display("[coinbase_prefix_parser] OK");
        else
            $display("[coinbase_prefix_parser] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("[coinbase_prefix_parser] ERROR");
        $finish;
    end

endmodule
